/* rtl/fltri_pkg.sv */
// shared types, constants and byte codes for the face line triangulator
`timescale 1ns / 1ps

package fltri_pkg;

  localparam int INDEX_BITS    = 24;
  localparam int MATERIAL_BITS = 16;
  localparam int ACC_W         = INDEX_BITS + 1;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(1) << INDEX_BITS;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [1:0] FS_POS = 2'd0;
  localparam logic [1:0] FS_TEX = 2'd1;
  localparam logic [1:0] FS_NRM = 2'd2;

  typedef struct packed {
    logic [7:0]               char_in;
    logic [INDEX_BITS-1:0]    vertex_count;
    logic [INDEX_BITS-1:0]    texcoord_count;
    logic [INDEX_BITS-1:0]    normal_count;
    logic [MATERIAL_BITS-1:0] material_in;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]    c0_pos;
    logic [INDEX_BITS-1:0]    c0_tex;
    logic [INDEX_BITS-1:0]    c0_nrm;
    logic [INDEX_BITS-1:0]    c1_pos;
    logic [INDEX_BITS-1:0]    c1_tex;
    logic [INDEX_BITS-1:0]    c1_nrm;
    logic [INDEX_BITS-1:0]    c2_pos;
    logic [INDEX_BITS-1:0]    c2_tex;
    logic [INDEX_BITS-1:0]    c2_nrm;
    logic [MATERIAL_BITS-1:0] tri_material;
  } out_item_t;

  // signed reference: sign plus magnitude
  typedef struct packed {
    logic             neg;
    logic [ACC_W-1:0] mag;
  } sref_t;

  // one finished corner and/or end of line, handed from parser to assembler
  typedef struct packed {
    logic                     corner;
    logic                     clear;
    sref_t                    pos_ref;
    sref_t                    tex_ref;
    sref_t                    nrm_ref;
    logic [INDEX_BITS-1:0]    vertex_count;
    logic [INDEX_BITS-1:0]    texcoord_count;
    logic [INDEX_BITS-1:0]    normal_count;
    logic [MATERIAL_BITS-1:0] material;
  } evt_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] pos;
    logic [INDEX_BITS-1:0] tex;
    logic [INDEX_BITS-1:0] nrm;
  } corner_t;

endpackage

/* rtl/fltri_front.sv */
// byte parser: classifies bytes, accumulates numbers, emits corner events
`timescale 1ns / 1ps

module fltri_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fltri_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output fltri_pkg::evt_t   q_evt
);
  import fltri_pkg::*;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_SIGN,
    CLS_SLASH,
    CLS_SPACE,
    CLS_NL,
    CLS_OTHER
  } bclass_t;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             neg_r, neg_nxt;
  logic [1:0]       fs_r, fs_nxt;
  logic             token_r, token_nxt;
  sref_t            pos_r, pos_nxt;
  sref_t            tex_r, tex_nxt;
  sref_t            nrm_r, nrm_nxt;

  bclass_t          cls;
  logic             accept;
  logic [ACC_W+3:0] prod;
  sref_t            cur_ref;
  sref_t            pos_c, tex_c, nrm_c;
  logic             corner_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (in_data.char_in) inside
      [CH_ZERO:CH_NINE]:                        cls = CLS_DIGIT;
      CH_PLUS, CH_MINUS:                        cls = CLS_SIGN;
      CH_SLASH:                                 cls = CLS_SLASH;
      CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR:    cls = CLS_SPACE;
      CH_NL:                                    cls = CLS_NL;
      default:                                  cls = CLS_OTHER;
    endcase
  end

  // acc * 10 + digit, saturating at 2^INDEX_BITS
  assign prod = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0}
              + (ACC_W+4)'(in_data.char_in - CH_ZERO);

  // current field folded into the held references
  always_comb begin
    cur_ref.neg = neg_r;
    cur_ref.mag = acc_r;
    pos_c = pos_r;
    tex_c = tex_r;
    nrm_c = nrm_r;
    if (fs_r == FS_POS) begin
      pos_c = cur_ref;
    end else if (fs_r == FS_TEX) begin
      if (acc_r != '0) tex_c = cur_ref;
    end else begin
      if (acc_r != '0) nrm_c = cur_ref;
    end
  end

  assign corner_end = token_r && (cls == CLS_SPACE || cls == CLS_NL);

  always_comb begin
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    fs_nxt    = fs_r;
    token_nxt = token_r;
    pos_nxt   = pos_r;
    tex_nxt   = tex_r;
    nrm_nxt   = nrm_r;
    unique case (cls)
      CLS_DIGIT: begin
        acc_nxt   = (prod > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : prod[ACC_W-1:0];
        token_nxt = 1'b1;
      end
      CLS_SIGN: begin
        neg_nxt   = (in_data.char_in == CH_MINUS);
        token_nxt = 1'b1;
      end
      CLS_SLASH: begin
        pos_nxt   = pos_c;
        tex_nxt   = tex_c;
        nrm_nxt   = nrm_c;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        if (fs_r != FS_NRM) fs_nxt = fs_r + 2'd1;
        token_nxt = 1'b1;
      end
      CLS_SPACE: begin
        if (token_r) begin
          pos_nxt   = '0;
          tex_nxt   = tex_c;
          nrm_nxt   = nrm_c;
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          fs_nxt    = FS_POS;
          token_nxt = 1'b0;
        end
      end
      CLS_NL: begin
        pos_nxt   = '0;
        tex_nxt   = '0;
        nrm_nxt   = '0;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        fs_nxt    = FS_POS;
        token_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign q_push = accept && (corner_end || cls == CLS_NL);

  always_comb begin
    q_evt.corner         = corner_end;
    q_evt.clear          = (cls == CLS_NL);
    q_evt.pos_ref        = pos_c;
    q_evt.tex_ref        = tex_c;
    q_evt.nrm_ref        = nrm_c;
    q_evt.vertex_count   = in_data.vertex_count;
    q_evt.texcoord_count = in_data.texcoord_count;
    q_evt.normal_count   = in_data.normal_count;
    q_evt.material       = in_data.material_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      neg_r   <= 1'b0;
      fs_r    <= FS_POS;
      token_r <= 1'b0;
      pos_r   <= '0;
      tex_r   <= '0;
      nrm_r   <= '0;
    end else if (accept) begin
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      fs_r    <= fs_nxt;
      token_r <= token_nxt;
      pos_r   <= pos_nxt;
      tex_r   <= tex_nxt;
      nrm_r   <= nrm_nxt;
    end
  end

endmodule

/* rtl/fltri_queue.sv */
// small register queue of corner events between parser and assembler
`timescale 1ns / 1ps

module fltri_queue #(
  parameter int DEPTH = fltri_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fltri_pkg::evt_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output fltri_pkg::evt_t head_data
);
  import fltri_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  evt_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = slot_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == LAST) ? '0 : wr_r + PTR_W'(1)) : wr_r;
    rd_nxt  = do_pop  ? ((rd_r == LAST) ? '0 : rd_r + PTR_W'(1)) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/fltri_back.sv */
// corner assembler: resolves references, keeps the fan, drives triangles
`timescale 1ns / 1ps

module fltri_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_data,
  input  logic                 q_valid,
  input  fltri_pkg::evt_t      q_evt,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fltri_pkg::out_item_t out_data
);
  import fltri_pkg::*;

  logic      flip_r;
  logic [1:0] cc_r, cc_nxt;
  corner_t   store_r [3];
  corner_t   store_nxt [3];
  out_item_t out_r, out_nxt;
  logic      out_valid_r;

  logic [1:0] j;
  corner_t   old_c, new_c, mid_c, far_c;
  logic      produces, out_free;

  function automatic logic [INDEX_BITS-1:0] resolve(
    input logic [INDEX_BITS-1:0] slot,
    input sref_t                 r,
    input logic [INDEX_BITS-1:0] count
  );
    logic [ACC_W-1:0] t;
    if (r.mag == '0) begin
      t = {1'b0, slot};
    end else if (r.neg) begin
      t = {1'b0, count} - r.mag;
    end else begin
      t = r.mag - ACC_W'(1);
    end
    return t[INDEX_BITS-1:0];
  endfunction

  assign j     = (cc_r == 2'd3) ? 2'd2 : cc_r;
  assign old_c = store_r[j];

  always_comb begin
    new_c.pos = resolve(old_c.pos, q_evt.pos_ref, q_evt.vertex_count);
    new_c.tex = resolve(old_c.tex, q_evt.tex_ref, q_evt.texcoord_count);
    new_c.nrm = resolve(old_c.nrm, q_evt.nrm_ref, q_evt.normal_count);
  end

  assign produces  = q_evt.corner && (j == 2'd2);
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = q_valid && (!produces || out_free);

  // winding flip swaps the second and third corner
  assign mid_c = flip_r ? new_c : store_r[1];
  assign far_c = flip_r ? store_r[1] : new_c;

  always_comb begin
    out_nxt.c0_pos       = store_r[0].pos;
    out_nxt.c0_tex       = store_r[0].tex;
    out_nxt.c0_nrm       = store_r[0].nrm;
    out_nxt.c1_pos       = mid_c.pos;
    out_nxt.c1_tex       = mid_c.tex;
    out_nxt.c1_nrm       = mid_c.nrm;
    out_nxt.c2_pos       = far_c.pos;
    out_nxt.c2_tex       = far_c.tex;
    out_nxt.c2_nrm       = far_c.nrm;
    out_nxt.tri_material = q_evt.material;
  end

  always_comb begin
    cc_nxt = cc_r;
    for (int k = 0; k < 3; k++) store_nxt[k] = store_r[k];
    if (q_evt.corner) begin
      if (j == 2'd2) begin
        store_nxt[1] = new_c;
        store_nxt[2] = new_c;
        cc_nxt       = 2'd2;
      end else begin
        store_nxt[j] = new_c;
        cc_nxt       = j + 2'd1;
      end
    end
    if (q_evt.clear) begin
      cc_nxt = '0;
      for (int k = 0; k < 3; k++) store_nxt[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && produces) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_r      <= 1'b0;
      cc_r        <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) store_r[k] <= '0;
    end else begin
      if (cfg_valid) flip_r <= cfg_data;
      if (q_pop) begin
        cc_r <= cc_nxt;
        for (int k = 0; k < 3; k++) store_r[k] <= store_nxt[k];
      end
      if (q_pop && produces) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/face_line_fan_triangulator_unit.sv */
// top level of the face line fan triangulator
`timescale 1ns / 1ps

// Takes one byte of a face line per input beat (in_data.char_in) together
// with the current vertex, texcoord and normal counts and the material.
// Corners are whitespace separated references v, v/t, v//n or v/t/n;
// a newline ends the line. From the third corner on, each finished corner
// sends one fan triangle out as an out beat with nine zero-based indices
// and the material.
// Throughput is one byte per cycle while the event queue is not full. The
// parser pushes the corner event of a triangle's terminating byte into a
// QUEUE_DEPTH-entry queue; the assembler pops it, resolves the three
// references and registers the triangle, which then drives out_valid.
// When the receiver stalls, the output register holds its beat and the
// queue absorbs further corner events; in_ready drops only when the queue
// is full. The cfg channel writes flip_winding (swap of corners one and
// two) and is always ready; write it only while the block is idle.
// Synchronous reset clears the line state, the queue, the output register
// and flip_winding, so in_ready is high once the reset edge has been taken.

module face_line_fan_triangulator_unit #(
  parameter int QDEPTH = fltri_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fltri_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fltri_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);
  import fltri_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  evt_t push_evt, head_evt;

  assign cfg_ready = 1'b1;

  fltri_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_evt    (push_evt)
  );

  fltri_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_evt),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_evt)
  );

  fltri_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_evt     (head_evt),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/fltri_checker.sv */
// port level checks for the face line fan triangulator, bound to the top
`timescale 1ns / 1ps

module fltri_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input fltri_pkg::out_item_t out_data,
  input logic                 cfg_ready
);

  // a stalled triangle beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out beat changed or dropped while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // reset empties the event queue, so the input side opens
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("in_ready low after reset");

  // queue fills only behind a stalled output
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output back pressure");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> cfg_ready)
    else $error("cfg channel not ready");

endmodule

bind face_line_fan_triangulator_unit fltri_checker u_fltri_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
